[rtl/core/eda_pkg.sv]
// Shared types and constants of the extent disk allocator.
package eda_pkg;

	localparam int MAX_EXTENTS_DEF = 64;
	localparam int RESULT_LIMIT    = 64;
	localparam logic [15:0] CAP_RESET = 16'd1024;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_DELETE  = 2'd1;
	localparam logic [1:0] REQ_SHOW    = 2'd2;
	localparam logic [1:0] REQ_COMPACT = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DISK_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_TBL_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  file_id;
		logic [15:0] req_size;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] offset;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  owner;
		logic [15:0] len;
	} entry_t;

	typedef struct packed {
		logic   init;
		logic   pop;
		logic   push;
		entry_t d;
	} chain_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_REWRITE,
		S_FLUSH,
		S_TAIL,
		S_RESULT
	} state_t;

endpackage

[rtl/core/eda_cell.sv]
// One extent cell of the table chain.
module eda_cell #(
	parameter int IDX = 0,
	parameter int QW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eda_pkg::chain_ctl_t ctl,
	input  logic [QW-1:0]      q,
	input  eda_pkg::entry_t    nxt,
	output eda_pkg::entry_t    ent
);
	import eda_pkg::*;

	localparam logic [QW-1:0] POS   = QW'(IDX);
	localparam logic [QW-1:0] POS_1 = QW'(IDX + 1);

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '{owner: 8'd0, len: CAP_RESET};
		end else if (ctl.init) begin
			if (IDX == 0) begin
				ent_q <= ctl.d;
			end
		end else if (ctl.pop) begin
			// shift toward the head; the pushed beat lands behind the last entry
			if (POS_1 < q) begin
				ent_q <= nxt;
			end else if (ctl.push && POS_1 == q) begin
				ent_q <= ctl.d;
			end
		end else if (ctl.push && POS == q) begin
			ent_q <= ctl.d;
		end
	end

	assign ent = ent_q;
endmodule

[rtl/core/eda_chain.sv]
// Row of extent cells operated as a shifting queue, with its fill count.
module eda_chain #(
	parameter int MAX_EXTENTS = eda_pkg::MAX_EXTENTS_DEF,
	parameter int QW          = $clog2(MAX_EXTENTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  eda_pkg::chain_ctl_t ctl,
	output logic [QW-1:0]       q,
	output eda_pkg::entry_t     head
);
	import eda_pkg::*;

	entry_t        ent [MAX_EXTENTS];
	logic [QW-1:0] q_q;

	for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
		entry_t nxt;
		if (g == MAX_EXTENTS - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ent[g+1];
		end
		eda_cell #(.IDX(g), .QW(QW)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.q     (q_q),
			.nxt   (nxt),
			.ent   (ent[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= QW'(1);
		end else if (ctl.init) begin
			q_q <= QW'(1);
		end else if (ctl.push && !ctl.pop) begin
			q_q <= q_q + QW'(1);
		end else if (ctl.pop && !ctl.push) begin
			q_q <= q_q - QW'(1);
		end
	end

	assign q    = q_q;
	assign head = ent[0];
endmodule

[rtl/core/eda_seq.sv]
// Request sequencer: walks the extent queue and rewrites it pass by pass.
module eda_seq #(
	parameter int MAX_EXTENTS = eda_pkg::MAX_EXTENTS_DEF,
	parameter int QW          = $clog2(MAX_EXTENTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  eda_pkg::req_t        req,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  eda_pkg::entry_t      head,
	input  logic [QW-1:0]        q,
	output eda_pkg::chain_ctl_t  ctl,
	output logic                 rsp_valid,
	output eda_pkg::rsp_t        rsp
);
	import eda_pkg::*;

	state_t        state_q, state_d;
	logic [1:0]    op_q;
	logic [7:0]    id_q;
	logic [15:0]   size_q;
	logic [15:0]   cap_q;
	logic [1:0]    st_q;
	logic [QW-1:0] cnt0_q, i_q, fidx_q, nout_q;
	logic          fit_q, sdone_q, nsplit_q, found_q;
	logic [16:0]   fsum_q, srem_q, used_q;
	logic [15:0]   pos_q, pend_off_q, rem_q;
	logic [6:0]    hits_q;
	logic          pend_v_q, split2_q, hold_v_q;
	entry_t        hold_q;

	logic          last_el, full, h_free, hit;
	logic          wr_split, wr_take;
	logic [15:0]   amt, tail_len;
	entry_t        dm;
	logic          d_merge, c_merge;
	logic [17:0]   fsum_add, used_add;

	assign last_el  = (i_q == cnt0_q - QW'(1));
	assign full     = (q == QW'(MAX_EXTENTS));
	assign h_free   = (head.owner == 8'd0);
	assign hit      = (head.owner == id_q) && (hits_q < 7'(RESULT_LIMIT));
	assign wr_split = fit_q ? (i_q == fidx_q) : (h_free && rem_q != 16'd0 && head.len > rem_q);
	assign wr_take  = !fit_q && h_free && rem_q != 16'd0 && head.len <= rem_q;
	assign amt      = fit_q ? size_q : rem_q;
	assign dm       = (head.owner == id_q) ? '{owner: 8'd0, len: head.len} : head;
	assign d_merge  = hold_v_q && hold_q.owner == 8'd0 && dm.owner == 8'd0;
	assign c_merge  = hold_v_q && hold_q.owner == head.owner;
	assign fsum_add = {1'b0, fsum_q} + 18'(head.len);
	assign used_add = {1'b0, used_q} + 18'(head.len);
	assign tail_len = (used_q < {1'b0, cap_q}) ? cap_q - used_q[15:0] : 16'd0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.req_type == REQ_COMPACT) begin
						state_d = S_REWRITE;
					end else if (req.file_id == 8'd0) begin
						state_d = S_RESULT;
					end else if (req.req_type == REQ_WRITE && req.req_size == 16'd0) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (last_el) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_RESULT;
				if (op_q == REQ_WRITE) begin
					if (fit_q) begin
						if (!full) state_d = S_REWRITE;
					end else if (fsum_q >= {1'b0, size_q} && !(nsplit_q && full)) begin
						state_d = S_REWRITE;
					end
				end else if (op_q == REQ_DELETE && found_q) begin
					state_d = S_REWRITE;
				end
			end
			S_REWRITE: begin
				if (ctl.pop && last_el) begin
					state_d = (op_q == REQ_WRITE) ? S_RESULT : S_FLUSH;
				end
			end
			S_FLUSH:  state_d = (op_q == REQ_COMPACT) ? S_TAIL : S_RESULT;
			S_TAIL:   state_d = S_RESULT;
			S_RESULT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy      = (state_q != S_IDLE);
		ctl       = '0;
		rsp_valid = 1'b0;
		rsp       = '{status: st_q, offset: 16'd0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (cfg_we) begin
					ctl.init = 1'b1;
					ctl.d    = '{owner: 8'd0, len: cfg_data};
				end
			end
			S_SCAN: begin
				// rotate the table through the head
				ctl.pop  = 1'b1;
				ctl.push = 1'b1;
				ctl.d    = head;
				if (op_q == REQ_SHOW && hit && pend_v_q) begin
					rsp_valid = 1'b1;
					rsp       = '{status: ST_OK, offset: pend_off_q, last: 1'b0};
				end
			end
			S_REWRITE: begin
				case (op_q)
					REQ_WRITE: begin
						if (wr_split && !split2_q) begin
							ctl.push = 1'b1;
							ctl.d    = '{owner: id_q, len: amt};
						end else if (wr_split) begin
							ctl.pop  = 1'b1;
							ctl.push = 1'b1;
							ctl.d    = '{owner: 8'd0, len: head.len - amt};
						end else if (wr_take) begin
							ctl.pop  = 1'b1;
							ctl.push = 1'b1;
							ctl.d    = '{owner: id_q, len: head.len};
						end else begin
							ctl.pop  = 1'b1;
							ctl.push = 1'b1;
							ctl.d    = head;
						end
					end
					REQ_DELETE: begin
						ctl.pop  = 1'b1;
						ctl.push = hold_v_q && !d_merge;
						ctl.d    = hold_q;
					end
					default: begin
						ctl.pop  = 1'b1;
						ctl.push = !h_free && hold_v_q && !c_merge;
						ctl.d    = hold_q;
					end
				endcase
			end
			S_FLUSH: begin
				ctl.push = hold_v_q;
				ctl.d    = hold_q;
			end
			S_TAIL: begin
				ctl.push = (tail_len != 16'd0 || nout_q == '0) && !full;
				ctl.d    = '{owner: 8'd0, len: tail_len};
			end
			S_RESULT: begin
				rsp_valid = 1'b1;
				if (op_q == REQ_SHOW) begin
					rsp.status = pend_v_q ? ST_OK : ST_NOT_FOUND;
					rsp.offset = pend_v_q ? pend_off_q : 16'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && cfg_we) cap_q <= cfg_data;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= req.req_type;
					id_q     <= req.file_id;
					size_q   <= req.req_size;
					st_q     <= (req.file_id == 8'd0 && req.req_type != REQ_COMPACT)
					            ? ST_NOT_FOUND : ST_OK;
					cnt0_q   <= q;
					i_q      <= '0;
					fit_q    <= 1'b0;
					fidx_q   <= '0;
					fsum_q   <= '0;
					srem_q   <= {1'b0, req.req_size};
					sdone_q  <= 1'b0;
					nsplit_q <= 1'b0;
					found_q  <= 1'b0;
					pos_q    <= '0;
					hits_q   <= '0;
					pend_v_q <= 1'b0;
					hold_v_q <= 1'b0;
					used_q   <= '0;
					nout_q   <= '0;
					split2_q <= 1'b0;
				end
			end
			S_SCAN: begin
				i_q   <= i_q + QW'(1);
				pos_q <= pos_q + head.len;
				case (op_q)
					REQ_WRITE: begin
						if (h_free && !fit_q) begin
							if (head.len > size_q) begin
								fit_q  <= 1'b1;
								fidx_q <= i_q;
							end else begin
								fsum_q <= fsum_add[17:16] != 2'd0 ? 17'h10000 : fsum_add[16:0];
							end
						end
						if (h_free && !sdone_q) begin
							if ({1'b0, head.len} < srem_q) begin
								srem_q <= srem_q - {1'b0, head.len};
							end else begin
								sdone_q  <= 1'b1;
								nsplit_q <= {1'b0, head.len} > srem_q;
							end
						end
					end
					REQ_DELETE: begin
						if (head.owner == id_q) found_q <= 1'b1;
					end
					default: begin
						if (hit) begin
							pend_v_q   <= 1'b1;
							pend_off_q <= pos_q;
							hits_q     <= hits_q + 7'd1;
						end
					end
				endcase
			end
			S_DECIDE: begin
				i_q   <= '0;
				rem_q <= size_q;
				if (op_q == REQ_WRITE) begin
					if (fit_q) begin
						if (full) st_q <= ST_TBL_FULL;
					end else if (fsum_q < {1'b0, size_q}) begin
						st_q <= ST_DISK_FULL;
					end else if (nsplit_q && full) begin
						st_q <= ST_TBL_FULL;
					end
				end else if (op_q == REQ_DELETE && !found_q) begin
					st_q <= ST_NOT_FOUND;
				end
			end
			S_REWRITE: begin
				if (ctl.pop) i_q <= i_q + QW'(1);
				case (op_q)
					REQ_WRITE: begin
						if (wr_split && !split2_q) begin
							split2_q <= 1'b1;
						end else if (wr_split) begin
							split2_q <= 1'b0;
							rem_q    <= 16'd0;
						end else if (wr_take) begin
							rem_q <= rem_q - head.len;
						end
					end
					REQ_DELETE: begin
						// merge runs of free extents into the held beat
						if (d_merge) begin
							hold_q.len <= hold_q.len + dm.len;
						end else begin
							hold_q   <= dm;
							hold_v_q <= 1'b1;
						end
					end
					default: begin
						if (!h_free) begin
							used_q <= used_add[17:16] != 2'd0 ? 17'h10000 : used_add[16:0];
							if (c_merge) begin
								hold_q.len <= hold_q.len + head.len;
							end else begin
								hold_q   <= head;
								hold_v_q <= 1'b1;
								if (hold_v_q) nout_q <= nout_q + QW'(1);
							end
						end
					end
				endcase
			end
			S_FLUSH: begin
				if (hold_v_q) nout_q <= nout_q + QW'(1);
			end
			default: ;
		endcase
	end
endmodule

[rtl/core/extent_disk_allocator.sv]
// Top level of the extent disk allocator.
// A request is taken when start is high and busy is low; results come as one-cycle
// rsp_valid strobes that the receiver cannot stall, the final one carrying last.
// The extent table is a row of MAX_EXTENTS cells working as a shifting queue; a
// sequencer walks it through the head cell, one extent per cycle except when a
// write splits an extent. A zero-size write, or a request other than compact that
// names id zero, goes straight to its result. A capacity write, taken only while
// idle, resets the table to one free extent.
module extent_disk_allocator #(
	parameter int MAX_EXTENTS = eda_pkg::MAX_EXTENTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  eda_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	output logic          rsp_valid,
	output eda_pkg::rsp_t rsp
);
	import eda_pkg::*;

	localparam int QW = $clog2(MAX_EXTENTS + 1);

	chain_ctl_t    ctl;
	entry_t        head;
	logic [QW-1:0] q;

	eda_chain #(.MAX_EXTENTS(MAX_EXTENTS), .QW(QW)) u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.q     (q),
		.head  (head)
	);

	eda_seq #(.MAX_EXTENTS(MAX_EXTENTS), .QW(QW)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.head     (head),
		.q        (q),
		.ctl      (ctl),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);
endmodule

[rtl/core/eda_chk.sv]
// Port-level checks of the extent disk allocator, bound to the top level.
module eda_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          rsp_valid,
	input eda_pkg::rsp_t rsp
);
	import eda_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");

	a_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> busy) else $error("result beat while idle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |=> !busy) else $error("busy after last beat");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.offset == 16'd0)
		else $error("error beat not final or offset set");
endmodule

bind extent_disk_allocator eda_chk u_chk (.*);

[sim/tb_top.sv]
// Testbench for the extent disk allocator: directed and random requests against a table model.
`timescale 1ns / 1ps

module tb_top;
	import eda_pkg::*;

	localparam int TBL_DEPTH = 64;
	localparam int SETTLE_CYCLES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic rsp_valid;
	rsp_t rsp;

	// table model
	logic [7:0] tbl_owner [TBL_DEPTH];
	logic [15:0] tbl_len [TBL_DEPTH];
	int unsigned tbl_count;
	logic [15:0] capacity;

	rsp_t expected_rsp [$];
	int unsigned err_count = 0;
	bit idle_gaps = 1'b1;

	extent_disk_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .rsp_valid(rsp_valid), .rsp(rsp)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void table_clear();
		for (int i = 0; i < TBL_DEPTH; i++) begin
			tbl_owner[i] = '0;
			tbl_len[i] = '0;
		end
		tbl_len[0] = capacity;
		tbl_count = 1;
	endfunction

	function automatic void table_insert(int unsigned pos, logic [7:0] id, logic [15:0] len);
		for (int unsigned k = tbl_count; k > pos; k--) begin
			tbl_owner[k] = tbl_owner[k - 1];
			tbl_len[k] = tbl_len[k - 1];
		end
		tbl_owner[pos] = id;
		tbl_len[pos] = len;
		tbl_count++;
	endfunction

	function automatic logic [1:0] alloc_file(logic [7:0] id, int unsigned size);
		int unsigned free_sum, rem;
		bit split;
		free_sum = 0;
		split = 1'b0;
		if (id == 0) return ST_NOT_FOUND;
		if (size == 0) return ST_OK;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_owner[i] != 0) continue;
			if (tbl_len[i] > size) begin
				if (tbl_count >= TBL_DEPTH) return ST_TBL_FULL;
				tbl_len[i] = tbl_len[i] - size[15:0];
				table_insert(i, id, size[15:0]);
				return ST_OK;
			end
			free_sum += tbl_len[i];
		end
		if (free_sum < size) return ST_DISK_FULL;
		rem = size;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_owner[i] != 0) continue;
			if (tbl_len[i] < rem) rem -= tbl_len[i];
			else begin
				split = tbl_len[i] > rem;
				break;
			end
		end
		if (split && tbl_count >= TBL_DEPTH) return ST_TBL_FULL;
		rem = size;
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_owner[i] != 0) continue;
			if (tbl_len[i] < rem) begin
				tbl_owner[i] = id;
				rem -= tbl_len[i];
			end else if (tbl_len[i] == rem) begin
				tbl_owner[i] = id;
				break;
			end else begin
				tbl_len[i] = tbl_len[i] - rem[15:0];
				table_insert(i, id, rem[15:0]);
				break;
			end
		end
		return ST_OK;
	endfunction

	function automatic logic [1:0] free_file(logic [7:0] id);
		int unsigned j;
		bit found;
		j = 0;
		found = 1'b0;
		if (id == 0) return ST_NOT_FOUND;
		for (int unsigned i = 0; i < tbl_count; i++)
			if (tbl_owner[i] == id) begin
				tbl_owner[i] = '0;
				found = 1'b1;
			end
		if (!found) return ST_NOT_FOUND;
		// merge adjacent free extents
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (j > 0 && tbl_owner[i] == 0 && tbl_owner[j - 1] == 0)
				tbl_len[j - 1] = tbl_len[j - 1] + tbl_len[i];
			else begin
				tbl_owner[j] = tbl_owner[i];
				tbl_len[j] = tbl_len[i];
				j++;
			end
		end
		for (int unsigned i = j; i < tbl_count; i++) begin
			tbl_owner[i] = '0;
			tbl_len[i] = '0;
		end
		tbl_count = j;
		return ST_OK;
	endfunction

	function automatic void repack_table();
		logic [7:0] new_owner [TBL_DEPTH];
		logic [15:0] new_len [TBL_DEPTH];
		int unsigned n, used, rem;
		n = 0;
		used = 0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			new_owner[i] = '0;
			new_len[i] = '0;
		end
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_owner[i] == 0) continue;
			used += tbl_len[i];
			if (n > 0 && new_owner[n - 1] == tbl_owner[i])
				new_len[n - 1] = new_len[n - 1] + tbl_len[i];
			else begin
				new_owner[n] = tbl_owner[i];
				new_len[n] = tbl_len[i];
				n++;
			end
		end
		rem = (used < capacity) ? capacity - used : 0;
		if ((rem > 0 || n == 0) && n < TBL_DEPTH) begin
			new_owner[n] = '0;
			new_len[n] = rem[15:0];
			n++;
		end
		tbl_owner = new_owner;
		tbl_len = new_len;
		tbl_count = n;
	endfunction

	function automatic void predict_request(req_t r);
		rsp_t e;
		int unsigned pos;
		int n;
		e = '0;
		e.last = 1'b1;
		if (r.req_type == REQ_SHOW) begin
			pos = 0;
			n = 0;
			if (r.file_id != 0)
				for (int unsigned i = 0; i < tbl_count && n < RESULT_LIMIT; i++) begin
					if (tbl_owner[i] == r.file_id) begin
						e.status = ST_OK;
						e.offset = pos[15:0];
						e.last = 1'b0;
						expected_rsp.insert(expected_rsp.size(), e);
						n++;
					end
					pos += tbl_len[i];
				end
			if (n == 0) begin
				e.status = ST_NOT_FOUND;
				e.offset = '0;
				e.last = 1'b1;
				expected_rsp.insert(expected_rsp.size(), e);
			end else
				expected_rsp[expected_rsp.size() - 1].last = 1'b1;
			return;
		end
		case (r.req_type)
			REQ_WRITE: e.status = alloc_file(r.file_id, r.req_size);
			REQ_DELETE: e.status = free_file(r.file_id);
			default: begin
				repack_table();
				e.status = ST_OK;
			end
		endcase
		expected_rsp.insert(expected_rsp.size(), e);
	endfunction

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			if (expected_rsp.size() == 0)
				report($sformatf("unexpected beat %p", rsp));
			else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status)
					report($sformatf("status %0d, want %0d", rsp.status, e.status));
				if (rsp.offset !== e.offset)
					report($sformatf("offset %0d, want %0d", rsp.offset, e.offset));
				if (rsp.last !== e.last)
					report($sformatf("last %0b, want %0b", rsp.last, e.last));
			end
		end
	end

	// called and returns at a rising edge; start stays high if the next item follows at once
	task automatic send_req(input logic [1:0] kind, input logic [7:0] id,
			input logic [15:0] size);
		int unsigned gap;
		req_t r;
		gap = idle_gaps ? $urandom_range(0, 5) : 0;
		r.req_type = kind;
		r.file_id = id;
		r.req_size = size;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		start <= 1'b1;
		do @(negedge clk); while (busy);
		@(posedge clk);
		predict_request(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] cap);
		drain();
		cfg_data <= cap;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity = cap;
		table_clear();
	endtask

	task automatic test_directed();
		send_req(REQ_SHOW, 8'd0, 16'd0);
		send_req(REQ_WRITE, 8'd0, 16'd5);
		send_req(REQ_DELETE, 8'd0, 16'd0);
		send_req(REQ_WRITE, 8'd9, 16'd0);
		send_req(REQ_WRITE, 8'd255, 16'd1);
		send_req(REQ_WRITE, 8'd1, 16'hFFFF);
		send_req(REQ_WRITE, 8'd2, 16'd100);
		send_req(REQ_WRITE, 8'd3, 16'd200);
		send_req(REQ_SHOW, 8'd255, 16'hFFFF);
		send_req(REQ_DELETE, 8'd7, 16'd0);
		send_req(REQ_DELETE, 8'd2, 16'd0);
		send_req(REQ_WRITE, 8'd4, 16'd400);
		send_req(REQ_SHOW, 8'd4, 16'd0);
		send_req(REQ_WRITE, 8'd5, 16'd723);
		send_req(REQ_SHOW, 8'd3, 16'd0);
		send_req(REQ_COMPACT, 8'd0, 16'd0);
		send_req(REQ_SHOW, 8'd4, 16'd0);
		send_req(REQ_DELETE, 8'd255, 16'd0);
		send_req(REQ_COMPACT, 8'hAA, 16'h5555);
	endtask

	task automatic test_capacity_edges();
		set_capacity(16'd0);
		send_req(REQ_WRITE, 8'd1, 16'd1);
		send_req(REQ_SHOW, 8'd1, 16'd0);
		send_req(REQ_COMPACT, 8'd0, 16'd0);
		set_capacity(16'hFFFF);
		send_req(REQ_WRITE, 8'd8, 16'h8000);
		send_req(REQ_WRITE, 8'd9, 16'h7FFF);
		send_req(REQ_SHOW, 8'd9, 16'd0);
		send_req(REQ_COMPACT, 8'd0, 16'd0);
		set_capacity(16'd1);
		send_req(REQ_WRITE, 8'd6, 16'd1);
		send_req(REQ_WRITE, 8'd7, 16'd1);
		send_req(REQ_DELETE, 8'd6, 16'd0);
	endtask

	// fill the table with alternating owners, then scatter one file over the holes
	task automatic test_table_full();
		set_capacity(16'd64);
		for (int i = 0; i < 63; i++)
			send_req(REQ_WRITE, (i % 2) ? 8'd2 : 8'd1, 16'd1);
		send_req(REQ_WRITE, 8'd30, 16'd1);
		send_req(REQ_WRITE, 8'd31, 16'd1);
		send_req(REQ_DELETE, 8'd30, 16'd0);
		send_req(REQ_WRITE, 8'd32, 16'd1);
		send_req(REQ_DELETE, 8'd32, 16'd0);
		send_req(REQ_DELETE, 8'd2, 16'd0);
		send_req(REQ_WRITE, 8'd3, 16'd32);
		send_req(REQ_SHOW, 8'd3, 16'd0);
		send_req(REQ_SHOW, 8'd1, 16'd0);
		send_req(REQ_COMPACT, 8'd0, 16'd0);
		send_req(REQ_SHOW, 8'd3, 16'd0);
	endtask

	task automatic test_random();
		for (int p = 0; p < 5; p++) begin
			logic [15:0] cap;
			case (p)
				0: cap = CAP_RESET;
				1: cap = 16'hFFFF;
				2: cap = 16'd40;
				default: cap = 16'($urandom_range(1, 4096));
			endcase
			set_capacity(cap);
			idle_gaps = (p != 3);
			for (int i = 0; i < 25; i++) begin
				int unsigned pick;
				logic [7:0] id;
				logic [15:0] size;
				pick = $urandom_range(0, 99);
				id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				                                 : 8'($urandom_range(1, 8));
				if ($urandom_range(0, 7) == 0) size = 16'($urandom_range(0, 16'hFFFF));
				else size = 16'($urandom_range(1, (cap > 8) ? cap / 6 : 2));
				if (pick < 50) send_req(REQ_WRITE, id, size);
				else if (pick < 72) send_req(REQ_DELETE, id, size);
				else if (pick < 94) send_req(REQ_SHOW, id, size);
				else send_req(REQ_COMPACT, id, size);
			end
		end
		idle_gaps = 1'b1;
	endtask

	initial begin
		capacity = CAP_RESET;
		table_clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity_edges();
		test_table_full();
		test_random();
		drain();
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
